### rtl/bbal_pkg.sv
// Shared types, constants and helpers for the bitmap block allocator.
package bbal_pkg;

  // Field widths fixed by the block's interface
  localparam int ADDR_W      = 48;
  localparam int MAP_BYTES_W = 10;
  localparam int CFG_INDEX_W = 1;

  localparam logic [7:0]             FULL_BYTE       = 8'hFF;
  localparam logic [MAP_BYTES_W-1:0] MAP_BYTES_RESET = 10'd512;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_BASE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_BYTES   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clr_write;
    logic div_init;
    logic div_step;
    logic sel_free;
    logic free_wr;
    logic scan_issue;
    logic scan_step;
    logic alloc_hit;
    logic alloc_mul;
    logic finish_alloc;
    logic finish_full;
    logic finish_range;
    logic finish_free;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_of_range;
    logic div_last;
    logic scan_hit;
    logic scan_last;
  } dp_stat_t;

  // Index of the lowest clear bit of a map byte
  function automatic logic [2:0] lowest_free(input logic [7:0] map_byte);
    logic [2:0] idx;
    idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!map_byte[b]) idx = 3'(b);
    end
    return idx;
  endfunction

endpackage

### rtl/bbal_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
module bbal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/bbal_datapath.sv
// Allocator datapath: config registers, map RAM, scan, divider and address math.
module bbal_datapath
  import bbal_pkg::*;
#(
  parameter int MAP_DEPTH   = 512,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  req_t                   request,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic                   done,
  output rsp_t                   response
);

  localparam int AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int NW    = MAP_BYTES_W;
  localparam int IW    = (AW > NW) ? AW : NW;
  localparam int BW    = AW + 3;                    // block index bits
  localparam int BBW   = $clog2(BLOCK_BYTES + 1);
  localparam int LIM_W = NW + 3 + BBW;
  localparam int PW    = BW + BBW;

  // Offset to block index: multiply by a rounded-up reciprocal of the block size
  localparam int LG    = $clog2(BLOCK_BYTES);       // block size rounded up to 2**LG
  localparam int XW    = BW + LG;                   // offset bits below the range limit
  localparam int CW    = 16;                        // offset bits per multiply step
  localparam int NCH   = (XW + CW - 1) / CW;        // multiply steps
  localparam int SW    = NCH * CW;
  localparam int DW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SH    = XW + LG;
  localparam int RW    = XW + 1;
  localparam int QW    = SW + RW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  // Configuration and persistent state
  logic [ADDR_W-1:0] region_base;
  logic [NW-1:0]     map_bytes;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     search_start;

  // Per-transfer working registers
  logic [ADDR_W-1:0] rel;
  logic [ADDR_W-1:0] limit;
  logic [SW-1:0]     div_src;
  logic [QW-1:0]     div_acc;
  logic [DW-1:0]     div_i;
  logic [BW-1:0]     blk;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     pend_addr;
  logic [NW-1:0]     scan_cnt;

  // Map RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [NW-1:0]     n_use;
  logic [AW-1:0]     scan_first;
  logic [AW-1:0]     scan_wrap;
  logic [CW+RW-1:0]  div_part;
  logic [BW-1:0]     quot;
  logic [AW-1:0]     free_byte;

  // Map size in use: zero counts as one, clamp to the map depth
  always_comb begin
    if (map_bytes == '0) begin
      n_use = NW'(1);
    end else if (32'(map_bytes) > MAP_DEPTH) begin
      n_use = NW'(MAP_DEPTH);
    end else begin
      n_use = map_bytes;
    end
  end

  // Scan start and wrapping increment
  assign scan_first = (IW'(search_start) < IW'(n_use)) ? search_start : '0;
  assign scan_wrap  = (IW'(scan_addr) + IW'(1) == IW'(n_use)) ? '0 : scan_addr + 1'b1;

  // One slice of the offset times the reciprocal; quotient sits above SH
  assign div_part  = (CW+RW)'(div_src[SW-1 -: CW]) * (CW+RW)'(RECIP);
  assign quot      = div_acc[SH +: BW];
  assign free_byte = quot[BW-1:3];

  // RAM port selection
  always_comb begin
    ram_we    = cmd.clr_write | cmd.free_wr | cmd.alloc_hit;
    ram_raddr = cmd.sel_free ? free_byte : scan_addr;
    if (cmd.clr_write) begin
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else if (cmd.free_wr) begin
      ram_waddr = free_byte;
      ram_wdata = ram_rdata & ~(8'h01 << quot[2:0]);
    end else begin
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata | (8'h01 << lowest_free(ram_rdata));
    end
  end

  bbal_ram #(
    .WIDTH (8),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller
  assign stat.clr_last     = (clr_addr == AW'(MAP_DEPTH - 1));
  assign stat.out_of_range = (rel >= limit);
  assign stat.div_last     = (div_i == '0);
  assign stat.scan_hit     = (ram_rdata != FULL_BYTE);
  assign stat.scan_last    = (scan_cnt == n_use - 1'b1);

  // Control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      map_bytes    <= MAP_BYTES_RESET;
      clr_addr     <= '0;
      search_start <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.finish_alloc | cmd.finish_full | cmd.finish_range | cmd.finish_free;
      if (cfg_write) begin
        case (cfg_index)
          REG_REGION_BASE: region_base <= cfg_data;
          REG_MAP_BYTES:   map_bytes   <= cfg_data[NW-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_write) clr_addr <= clr_addr + 1'b1;
      if (cmd.alloc_hit) search_start <= pend_addr;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rel       <= request.release_address - region_base;
      limit     <= ADDR_W'(LIM_W'({n_use, 3'b000}) * LIM_W'(BLOCK_BYTES));
      scan_addr <= scan_first;
      scan_cnt  <= '0;
    end

    // Divide by the block size: reciprocal multiply, one 16-bit slice per cycle
    if (cmd.div_init) begin
      div_src <= SW'(rel[XW-1:0]);
      div_acc <= '0;
      div_i   <= DW'(NCH - 1);
    end
    if (cmd.div_step) begin
      div_acc <= (div_acc << CW) + QW'(div_part);
      div_src <= div_src << CW;
      div_i   <= div_i - 1'b1;
    end

    // Next-fit scan, one map byte per cycle
    if (cmd.scan_issue || cmd.scan_step) begin
      pend_addr <= scan_addr;
      scan_addr <= scan_wrap;
    end
    if (cmd.scan_step) scan_cnt <= scan_cnt + 1'b1;

    if (cmd.alloc_hit) blk  <= {pend_addr, lowest_free(ram_rdata)};
    if (cmd.alloc_mul) prod <= PW'(blk) * PW'(BLOCK_BYTES);

    // Result register
    if (cmd.finish_alloc) begin
      response.block_address <= region_base + ADDR_W'(prod);
      response.status        <= STATUS_DONE;
    end else if (cmd.finish_full) begin
      response.block_address <= '0;
      response.status        <= STATUS_FULL;
    end else if (cmd.finish_range) begin
      response.block_address <= '0;
      response.status        <= STATUS_RANGE;
    end else if (cmd.finish_free) begin
      response.block_address <= '0;
      response.status        <= STATUS_DONE;
    end
  end

endmodule

### rtl/bbal_ctrl.sv
// Allocator controller: clearing pass, allocate scan and free sequencing.
module bbal_ctrl
  import bbal_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     mode,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_CHECK   = 10'b00_0000_0100,
    S_DIV     = 10'b00_0000_1000,
    S_FREE_RD = 10'b00_0001_0000,
    S_FREE_WR = 10'b00_0010_0000,
    S_ISSUE   = 10'b00_0100_0000,
    S_SCAN    = 10'b00_1000_0000,
    S_MUL     = 10'b01_0000_0000,
    S_ADD     = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = mode ? S_CHECK : S_ISSUE;
        end
      end
      S_CHECK: begin
        if (stat.out_of_range) begin
          cmd.finish_range = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_FREE_RD;
      end
      S_FREE_RD: begin
        cmd.sel_free = 1'b1;
        state_next   = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr     = 1'b1;
        cmd.finish_free = 1'b1;
        state_next      = S_IDLE;
      end
      S_ISSUE: begin
        cmd.scan_issue = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.alloc_hit = 1'b1;
          state_next    = S_MUL;
        end else if (stat.scan_last) begin
          cmd.finish_full = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.alloc_mul = 1'b1;
        state_next    = S_ADD;
      end
      S_ADD: begin
        cmd.finish_alloc = 1'b1;
        state_next       = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/bitmap_block_allocator_core.sv
// Top level of the bitmap next-fit block allocator.
//
// After reset the block holds busy high while it clears all MAP_DEPTH bytes
// of the used map, one byte per cycle; configuration writes are taken then as
// always. A request is taken on a clock edge with start high and busy low,
// and one result follows as a single-cycle done strobe; it must be captured
// in that cycle, and busy is already low then so the next request can go in.
// An allocation scans the map one byte a cycle through the map RAM's read
// port, reading from 1 byte up to the map size in use; with no free block
// it reads every byte in use. A free divides the offset by BLOCK_BYTES as a
// reciprocal multiply over 16-bit slices, followed by a read-modify-write of
// the map byte; a free address out of range returns without the divide.
module bitmap_block_allocator_core
  import bbal_pkg::*;
#(
  parameter int MAP_DEPTH   = 512,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  req_t                   request,
  output logic                   done,
  output rsp_t                   response,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bbal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (request.mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bbal_datapath #(
    .MAP_DEPTH   (MAP_DEPTH),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .response  (response)
  );

endmodule

### rtl/bbal_checker.sv
// Port-level checks for the block allocator, bound to the top level.
module bbal_port_checker
  import bbal_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t response
);

  // Reset always starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // A result strobe lasts one cycle and never comes back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");

  // No result in the cycle right after a transfer is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (!done && busy))
    else $error("result or idle right after request transfer");

  // A result is only shown while the block is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // Failed requests report a zero address
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && (response.status == STATUS_FULL || response.status == STATUS_RANGE))
      |-> (response.block_address == '0))
    else $error("nonzero address with failure status");

endmodule

bind bitmap_block_allocator_core bbal_port_checker u_checker (.*);
